FILE: hw/rtl/sfoc_pkg.sv
package sfoc_pkg;

  // Q.12 fixed point widths
  localparam int unsigned CoefW  = 16;
  localparam int unsigned EstW   = 24;
  localparam int unsigned OpndW  = 25;
  localparam int unsigned ProdW  = CoefW + OpndW;
  localparam int unsigned AccW   = 44;
  localparam int unsigned LvlW   = 15;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned NumW   = LvlW + CodeW;
  localparam int unsigned PcW    = 4;
  localparam int unsigned CfgIdxW = 3;

  // lower drive clamp
  localparam logic signed [OpndW-1:0] SatLow = '0;

  // plant and input matrices, Q.12
  localparam logic signed [CoefW-1:0] CoefA11 = 16'sd3820;
  localparam logic signed [CoefW-1:0] CoefA21 = -16'sd4692;
  localparam logic signed [CoefW-1:0] CoefA22 = 16'sd1868;
  localparam logic signed [CoefW-1:0] CoefB1  = -16'sd483;
  localparam logic signed [CoefW-1:0] CoefB2  = 16'sd328;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRefGain  = 3'd0,
    CfgGainOne  = 3'd1,
    CfgGainTwo  = 3'd2,
    CfgObsOne   = 3'd3,
    CfgObsTwo   = 3'd4,
    CfgRefLevel = 3'd5,
    CfgDcOffset = 3'd6,
    CfgSatMax   = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    CoefK0  = 4'd0,
    CoefG1  = 4'd1,
    CoefG2  = 4'd2,
    CoefL1  = 4'd3,
    CoefL2  = 4'd4,
    CoefSA11 = 4'd5,
    CoefSA21 = 4'd6,
    CoefSA22 = 4'd7,
    CoefSB1  = 4'd8,
    CoefSB2  = 4'd9
  } coef_sel_e;

  typedef enum logic [2:0] {
    OpndRef = 3'd0,
    OpndX1  = 3'd1,
    OpndX2  = 3'd2,
    OpndU   = 3'd3,
    OpndErr = 3'd4
  } opnd_sel_e;

  typedef enum logic [1:0] {
    AccNop  = 2'd0,
    AccLoad = 2'd1,
    AccAdd  = 2'd2,
    AccSub  = 2'd3
  } acc_op_e;

  typedef enum logic [1:0] {
    WbNone = 2'd0,
    WbU    = 2'd1,
    WbN1   = 2'd2,
    WbN2   = 2'd3
  } wb_e;

  typedef enum logic [1:0] {
    JmpNone    = 2'd0,
    JmpDivBusy = 2'd1,
    JmpOutFull = 2'd2
  } jmp_e;

  typedef struct packed {
    coef_sel_e      coef;
    opnd_sel_e      opnd;
    acc_op_e        acc;
    wb_e            wb;
    logic           div_start;
    logic           div_ref;     // 0: drive value, 1: reference value
    logic           cap_drive;
    logic           emit;
    logic           last;
    jmp_e           jmp;
    logic [PcW-1:0] tgt;
  } ucode_t;

  // The accumulate field acts on the product issued by the previous step.
  function automatic ucode_t ucode(logic [PcW-1:0] pc);
    ucode_t w;
    w = '{coef: CoefK0, opnd: OpndRef, acc: AccNop, wb: WbNone, div_start: 1'b0,
          div_ref: 1'b0, cap_drive: 1'b0, emit: 1'b0, last: 1'b0, jmp: JmpNone,
          tgt: '0};
    case (pc)
      4'd0: begin
        w.coef = CoefK0; w.opnd = OpndRef;
      end
      4'd1: begin
        w.coef = CoefG1; w.opnd = OpndX1; w.acc = AccLoad;
      end
      4'd2: begin
        w.coef = CoefG2; w.opnd = OpndX2; w.acc = AccSub;
      end
      4'd3: begin
        w.coef = CoefSA11; w.opnd = OpndX1; w.acc = AccSub;
      end
      4'd4: begin
        w.coef = CoefL1; w.opnd = OpndErr; w.acc = AccLoad; w.wb = WbU;
      end
      4'd5: begin
        w.coef = CoefSB1; w.opnd = OpndU; w.acc = AccAdd; w.div_start = 1'b1;
      end
      4'd6: begin
        w.coef = CoefSA21; w.opnd = OpndX1; w.acc = AccAdd;
      end
      4'd7: begin
        w.coef = CoefSA22; w.opnd = OpndX2; w.acc = AccLoad; w.wb = WbN1;
      end
      4'd8: begin
        w.coef = CoefSB2; w.opnd = OpndU; w.acc = AccAdd;
      end
      4'd9: begin
        w.coef = CoefL2; w.opnd = OpndErr; w.acc = AccAdd;
      end
      4'd10: begin
        w.acc = AccAdd;
      end
      4'd11: begin
        w.wb = WbN2;
      end
      4'd12: begin
        w.jmp = JmpDivBusy; w.tgt = 4'd12;
      end
      4'd13: begin
        w.cap_drive = 1'b1; w.div_start = 1'b1; w.div_ref = 1'b1;
      end
      4'd14: begin
        w.jmp = JmpDivBusy; w.tgt = 4'd14;
      end
      4'd15: begin
        w.emit = 1'b1; w.last = 1'b1; w.jmp = JmpOutFull; w.tgt = 4'd15;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/state_feedback_observer_controller.sv
// State-feedback controller with a two-state predictive observer. Each item (reference
// switch plus one measured sample) yields one result: the DAC code of the clamped,
// offset drive and the DAC code of the offset reference. A microcoded sequencer steps
// one shared 16 x 25 bit multiplier and a 44-bit accumulator through the drive and
// both estimate updates, and a bit-serial scaler forms each DAC code. The 16-step
// program holds twelve multiply-accumulate and write-back steps, two waits on the
// scaler, and the capture and emit steps. One item is worked on at a time.
// A new item is taken while a finished result still waits at the output,
// and the sequencer then holds on its emit step until the output register is free.
module state_feedback_observer_controller
  import sfoc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               ref_high_i,
  input  logic signed [15:0] y_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CodeW-1:0]   drive_code_o,
  output logic [CodeW-1:0]   ref_code_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoefW-1:0]   cfg_data_i
);

  // configuration
  logic signed [CoefW-1:0] ref_gain_q, gain_one_q, gain_two_q, obs_one_q, obs_two_q;
  logic [LvlW-1:0]         ref_level_q, dc_offset_q, sat_max_q;

  // sequencer
  logic           run_q;
  logic [PcW-1:0] pc_q;
  ucode_t         uc;
  logic           jump;
  logic           in_acc;

  // datapath
  logic                    ref_high_q;
  logic signed [15:0]      y_q;
  logic signed [EstW-1:0]  est_first_q, est_second_q, u_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  rnd;
  logic signed [EstW-1:0]  rnd_sat;
  logic signed [CoefW-1:0] coef;
  logic signed [OpndW-1:0] opnd;
  logic signed [15:0]      ref_val;
  logic signed [OpndW-1:0] err;
  logic signed [OpndW-1:0] drive_lvl, ref_lvl;
  logic [LvlW-1:0]         div_num;
  logic                    div_busy;
  logic [CodeW-1:0]        div_quo;
  logic [CodeW-1:0]        drive_stage_q;

  logic             out_valid_q;
  logic [CodeW-1:0] drive_code_q, ref_code_q;
  logic             out_full;

  function automatic logic [LvlW-1:0] clamp_lvl(logic signed [OpndW-1:0] v,
                                                logic [LvlW-1:0] full);
    logic signed [OpndW-1:0] r;
    r = v;
    if (r < SatLow) r = SatLow;
    if (r > $signed(OpndW'(full))) r = $signed(OpndW'(full));
    if (r <= 0) r = '0;
    return r[LvlW-1:0];
  endfunction

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_gain_q  <= 16'sd2334;
      gain_one_q  <= 16'sd11907;
      gain_two_q  <= 16'sd6701;
      obs_one_q   <= -16'sd2062;
      obs_two_q   <= 16'sd4049;
      ref_level_q <= 15'd2048;
      dc_offset_q <= 15'd10240;
      sat_max_q   <= 15'd16712;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgRefGain:  ref_gain_q  <= cfg_data_i;
        CfgGainOne:  gain_one_q  <= cfg_data_i;
        CfgGainTwo:  gain_two_q  <= cfg_data_i;
        CfgObsOne:   obs_one_q   <= cfg_data_i;
        CfgObsTwo:   obs_two_q   <= cfg_data_i;
        CfgRefLevel: ref_level_q <= cfg_data_i[LvlW-1:0];
        CfgDcOffset: dc_offset_q <= cfg_data_i[LvlW-1:0];
        CfgSatMax:   sat_max_q   <= cfg_data_i[LvlW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  assign uc       = ucode(pc_q);
  assign out_full = out_valid_q && out_stall_i;
  assign in_stall_o = run_q;
  assign in_acc   = in_valid_i && !run_q;

  always_comb begin
    case (uc.jmp)
      JmpNone:    jump = 1'b0;
      JmpDivBusy: jump = div_busy;
      JmpOutFull: jump = out_full;
      default:    jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      pc_q  <= '0;
    end else if (in_acc) begin
      run_q <= 1'b1;
      pc_q  <= '0;
    end else if (run_q) begin
      if (jump) begin
        pc_q <= uc.tgt;
      end else if (uc.last) begin
        run_q <= 1'b0;
      end else begin
        pc_q <= pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ref_high_q <= ref_high_i;
      y_q        <= y_sample_i;
    end
  end

  // operand selection
  assign ref_val = ref_high_q ? $signed({1'b0, ref_level_q}) : -$signed({1'b0, ref_level_q});
  assign err     = OpndW'(y_q) - OpndW'(est_second_q);

  always_comb begin
    case (uc.coef)
      CoefK0:   coef = ref_gain_q;
      CoefG1:   coef = gain_one_q;
      CoefG2:   coef = gain_two_q;
      CoefL1:   coef = obs_one_q;
      CoefL2:   coef = obs_two_q;
      CoefSA11: coef = CoefA11;
      CoefSA21: coef = CoefA21;
      CoefSA22: coef = CoefA22;
      CoefSB1:  coef = CoefB1;
      CoefSB2:  coef = CoefB2;
      default:  coef = '0;
    endcase
  end

  always_comb begin
    case (uc.opnd)
      OpndRef: opnd = OpndW'(ref_val);
      OpndX1:  opnd = OpndW'(est_first_q);
      OpndX2:  opnd = OpndW'(est_second_q);
      OpndU:   opnd = OpndW'(u_q);
      OpndErr: opnd = err;
      default: opnd = '0;
    endcase
  end

  // round half up to Q.12, then saturate to 24 bits
  assign rnd = (acc_q + AccW'(2048)) >>> 12;
  always_comb begin
    if (rnd > AccW'(8388607)) begin
      rnd_sat = 24'sh7fffff;
    end else if (rnd < -AccW'(8388608)) begin
      rnd_sat = -24'sh800000;
    end else begin
      rnd_sat = rnd[EstW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_q) begin
      prod_q <= coef * opnd;
      case (uc.acc)
        AccNop:  ;
        AccLoad: acc_q <= AccW'(prod_q);
        AccAdd:  acc_q <= acc_q + AccW'(prod_q);
        AccSub:  acc_q <= acc_q - AccW'(prod_q);
        default: ;
      endcase
      if (uc.wb == WbU) begin
        u_q <= rnd_sat;
      end
      if (uc.cap_drive) begin
        drive_stage_q <= div_quo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_first_q  <= '0;
      est_second_q <= '0;
    end else if (run_q) begin
      case (uc.wb)
        WbN1:    est_first_q  <= rnd_sat;
        WbN2:    est_second_q <= rnd_sat;
        default: ;
      endcase
    end
  end

  // DAC scaling
  assign drive_lvl = OpndW'(u_q) + OpndW'(dc_offset_q);
  assign ref_lvl   = OpndW'(ref_val) + OpndW'(dc_offset_q);
  assign div_num   = uc.div_ref ? clamp_lvl(ref_lvl, sat_max_q)
                                : clamp_lvl(drive_lvl, sat_max_q);

  sfoc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (run_q && uc.div_start),
    .num_i   (div_num),
    .full_i  (sat_max_q),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (run_q && uc.emit && !out_full) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_q && uc.emit && !out_full) begin
      drive_code_q <= drive_stage_q;
      ref_code_q   <= div_quo;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign drive_code_o = drive_code_q;
  assign ref_code_o   = ref_code_q;

endmodule

FILE: hw/rtl/sfoc_div.sv
// Scales a clamped level to a DAC code: floor(255 * num / full), one bit a cycle.
module sfoc_div
  import sfoc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [LvlW-1:0]  num_i,
  input  logic [LvlW-1:0]  full_i,
  output logic             busy_o,
  output logic [CodeW-1:0] quo_o
);

  logic [NumW-1:0]          rem_q, rem_d;
  logic [LvlW-1:0]          den_q, den_d;
  logic [CodeW-1:0]         quo_q, quo_d;
  logic [$clog2(CodeW)-1:0] cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic [NumW-1:0]          trial;

  assign trial = NumW'(den_q) << cnt_q;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      // 255 * num as a shift and subtract
      rem_d  = {num_i, {CodeW{1'b0}}} - NumW'(num_i);
      den_d  = full_i;
      quo_d  = '0;
      cnt_d  = '1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (den_q != '0 && rem_q >= trial) begin
        rem_d        = rem_q - trial;
        quo_d[cnt_q] = 1'b1;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule
